@@ sv/mlfq_pkg.sv @@
// Package for the feedback-queue scheduler: payload structs, codes, constants.
// Used by every module of the scheduler; depends on nothing.
package mlfq_pkg;
  localparam int SLOTS = 64;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int PID_BITS = 16;

  localparam logic [2:0] K_ADMIT = 3'd0;
  localparam logic [2:0] K_TICK = 3'd1;
  localparam logic [2:0] K_DISPATCH = 3'd2;
  localparam logic [2:0] K_RETURN = 3'd3;
  localparam logic [2:0] K_SETPRIO = 3'd4;
  localparam logic [2:0] K_LOCK = 3'd5;
  localparam logic [2:0] K_UNLOCK = 3'd6;
  localparam logic [2:0] K_SETSTAT = 3'd7;

  localparam logic [2:0] R_OK = 3'd0;
  localparam logic [2:0] R_NONE = 3'd1;
  localparam logic [2:0] R_FULL = 3'd2;
  localparam logic [2:0] R_IGNORED = 3'd3;
  localparam logic [2:0] R_LOCKFAIL = 3'd4;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_RUNNABLE = 2'd2;
  localparam logic [1:0] ST_RUNNING = 2'd3;

  localparam logic [2:0] CFG_BOOST = 3'd0;
  localparam logic [2:0] CFG_Q0 = 3'd1;
  localparam logic [2:0] CFG_Q1 = 3'd2;
  localparam logic [2:0] CFG_Q2 = 3'd3;
  localparam logic [2:0] CFG_KEY = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic still_runnable;
    logic [15:0] target_pid;
    logic [1:0] new_priority;
    logic [31:0] password;
    logic [5:0] target_slot;
    logic [1:0] new_status;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot;
    logic [15:0] pid;
    logic [1:0] level;
  } out_word_t;

  // one slot entry; birth kept with a bias of 4
  typedef struct packed {
    logic [1:0] status;
    logic [PID_BITS-1:0] pid;
    logic [1:0] level;
    logic [1:0] prio;
    logic [9:0] birth;
    logic [7:0] quantum;
    logic locked;
  } slot_t;

  function automatic slot_t slot_reset_val();
    slot_t s;
    s = '0;
    s.prio = 2'd3;
    return s;
  endfunction
endpackage

@@ sv/mlfq_process_scheduler_core.sv @@
// Top level of the three-level feedback-queue scheduler.
// Depends on mlfq_pkg and mlfq_ram; holds the sequencer that sweeps the slot table.
//
//  channel | ports                       | word
//  input   | in_valid/in_ready/in_data   | mlfq_pkg::in_word_t
//  output  | out_valid/out_ready/out_data| mlfq_pkg::out_word_t
//  config  | cfg_we/cfg_index/cfg_data   | 32-bit register write
//
// One word at a time; a table pass reads one slot a cycle.
// Admit and set priority stop at the first match (at most one pass); dispatch
// takes one pass, two, or three with a level reset; a boosting tick or lock
// return adds one pass; other words modify at most one slot, then read back the slot.
// After reset a clearing pass writes every slot before in_ready rises.
// A result waits in the output register; the next word is taken meanwhile.
module mlfq_process_scheduler_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mlfq_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mlfq_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  localparam int SB = mlfq_pkg::SLOT_BITS;

  // sequencer states
  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;  // generic pass, one slot a cycle
  localparam logic [3:0] S_SINGLE  = 4'd3;  // read one slot, modify, write
  localparam logic [3:0] S_EMIT    = 4'd4;  // read slot for report
  localparam logic [3:0] S_OUT     = 4'd5;  // wait for output register free

  // pass kinds
  localparam logic [2:0] P_ADMIT  = 3'd0;
  localparam logic [2:0] P_SETPR  = 3'd1;
  localparam logic [2:0] P_BOOST  = 3'd2;
  localparam logic [2:0] P_DSEL   = 3'd3;  // lock search and levels present
  localparam logic [2:0] P_DBEST  = 3'd4;  // best of chosen level
  localparam logic [2:0] P_LVRST  = 3'd5;  // birth reset of chosen level

  logic [3:0] state_r, state_nxt;
  logic [2:0] pass_r, pass_nxt;
  mlfq_pkg::in_word_t req_r, req_nxt;

  logic [7:0] boost_r, q0_r, q1_r, q2_r;
  logic [31:0] key_r;

  logic [7:0] tick_r, tick_nxt;
  logic lock_act_r, lock_act_nxt;
  logic [1:0] prev_lv_r, prev_lv_nxt;
  logic [mlfq_pkg::PID_BITS-1:0] next_id_r, next_id_nxt;
  logic cur_v_r, cur_v_nxt;
  logic [SB-1:0] cur_r, cur_nxt;
  logic by_lock_r, by_lock_nxt;

  // scan pipeline: address issued, address whose data arrives
  logic [SB:0] addr_r, addr_nxt;
  logic rv_r, rv_nxt;
  logic [SB-1:0] raddr_d_r, raddr_d_nxt;
  logic skip_v_r, skip_v_nxt;
  logic [SB-1:0] skip_r, skip_nxt;

  // dispatch search
  logic found_r, found_nxt;
  logic [SB-1:0] best_r, best_nxt;
  mlfq_pkg::slot_t best_e_r, best_e_nxt;
  logic [2:0] lvnz_r, lvnz_nxt;
  logic [1:0] lvl_r, lvl_nxt;

  // report
  logic [2:0] rst_code_r, rst_code_nxt;
  logic rhave_r, rhave_nxt;
  logic [SB-1:0] rslot_r, rslot_nxt;

  logic ovalid_r, ovalid_nxt;
  mlfq_pkg::out_word_t odata_r, odata_nxt;

  logic we;
  logic [SB-1:0] waddr, raddr;
  mlfq_pkg::slot_t wdata, rdata;

  mlfq_ram u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boost_r <= 8'd100;
      q0_r <= 8'd4;
      q1_r <= 8'd6;
      q2_r <= 8'd8;
      key_r <= 32'd2019038513;
    end else if (cfg_we) begin
      case (cfg_index)
        mlfq_pkg::CFG_BOOST: boost_r <= cfg_data[7:0];
        mlfq_pkg::CFG_Q0:    q0_r <= cfg_data[7:0];
        mlfq_pkg::CFG_Q1:    q1_r <= cfg_data[7:0];
        mlfq_pkg::CFG_Q2:    q2_r <= cfg_data[7:0];
        mlfq_pkg::CFG_KEY:   key_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // candidate compare: is entry e better than best b at level lv
  function automatic logic better(input mlfq_pkg::slot_t e, input mlfq_pkg::slot_t b,
                                  input logic [1:0] lv);
    logic r;
    if (lv == 2'd2 && e.prio != b.prio) r = e.prio < b.prio;
    else if (e.birth != b.birth) r = e.birth < b.birth;
    else r = e.pid < b.pid;
    return r;
  endfunction

  function automatic logic [1:0] lowest(input logic [2:0] nz);
    logic [1:0] r;
    if (nz[0]) r = 2'd0;
    else if (nz[1]) r = 2'd1;
    else r = 2'd2;
    return r;
  endfunction

  logic out_free;
  assign out_free = !ovalid_r || out_ready;

  always_comb begin
    mlfq_pkg::slot_t e;
    logic last;
    logic [1:0] lw;
    state_nxt = state_r;
    pass_nxt = pass_r;
    req_nxt = req_r;
    tick_nxt = tick_r;
    lock_act_nxt = lock_act_r;
    prev_lv_nxt = prev_lv_r;
    next_id_nxt = next_id_r;
    cur_v_nxt = cur_v_r;
    cur_nxt = cur_r;
    by_lock_nxt = by_lock_r;
    addr_nxt = addr_r;
    rv_nxt = 1'b0;
    raddr_d_nxt = addr_r[SB-1:0];
    skip_v_nxt = skip_v_r;
    skip_nxt = skip_r;
    found_nxt = found_r;
    best_nxt = best_r;
    best_e_nxt = best_e_r;
    lvnz_nxt = lvnz_r;
    lvl_nxt = lvl_r;
    rst_code_nxt = rst_code_r;
    rhave_nxt = rhave_r;
    rslot_nxt = rslot_r;
    ovalid_nxt = ovalid_r && !out_ready;
    odata_nxt = odata_r;
    we = 1'b0;
    waddr = raddr_d_r;
    wdata = rdata;
    raddr = addr_r[SB-1:0];
    e = rdata;
    last = 1'b0;
    lw = 2'd0;

    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        waddr = addr_r[SB-1:0];
        wdata = mlfq_pkg::slot_reset_val();
        addr_nxt = addr_r + 1'b1;
        if (addr_r == (SB+1)'(mlfq_pkg::SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          addr_nxt = '0;
          rhave_nxt = 1'b0;
          rslot_nxt = '0;
          rst_code_nxt = mlfq_pkg::R_OK;
          state_nxt = S_EMIT;
          case (in_data.kind)
            mlfq_pkg::K_ADMIT: begin
              pass_nxt = P_ADMIT; state_nxt = S_SCAN;
            end
            mlfq_pkg::K_SETPRIO: begin
              pass_nxt = P_SETPR; state_nxt = S_SCAN;
            end
            mlfq_pkg::K_TICK: begin
              tick_nxt = (tick_r == 8'd255) ? tick_r : tick_r + 8'd1;
              rhave_nxt = cur_v_r; rslot_nxt = cur_r;
              if (tick_nxt == boost_r && !lock_act_r) begin
                tick_nxt = '0;
                pass_nxt = P_BOOST; skip_v_nxt = 1'b0; state_nxt = S_SCAN;
              end
            end
            mlfq_pkg::K_DISPATCH: begin
              if (cur_v_r) begin
                rst_code_nxt = mlfq_pkg::R_IGNORED;
                rhave_nxt = 1'b1; rslot_nxt = cur_r;
              end else begin
                pass_nxt = P_DSEL; state_nxt = S_SCAN;
                found_nxt = 1'b0; lvnz_nxt = '0;
              end
            end
            mlfq_pkg::K_RETURN: begin
              if (!cur_v_r) rst_code_nxt = mlfq_pkg::R_IGNORED;
              else begin
                addr_nxt = {1'b0, cur_r}; state_nxt = S_SINGLE;
              end
            end
            mlfq_pkg::K_LOCK: begin
              if (lock_act_r) begin
                rst_code_nxt = mlfq_pkg::R_IGNORED;
                rhave_nxt = cur_v_r; rslot_nxt = cur_r;
              end else if (in_data.password != key_r) begin
                rst_code_nxt = mlfq_pkg::R_LOCKFAIL;
                rhave_nxt = cur_v_r; rslot_nxt = cur_r;
                if (cur_v_r) begin
                  addr_nxt = {1'b0, cur_r}; state_nxt = S_SINGLE;
                end
              end else if (!cur_v_r) begin
                rst_code_nxt = mlfq_pkg::R_IGNORED;
              end else begin
                tick_nxt = '0; lock_act_nxt = 1'b1;
                rhave_nxt = 1'b1; rslot_nxt = cur_r;
                addr_nxt = {1'b0, cur_r}; state_nxt = S_SINGLE;
              end
            end
            mlfq_pkg::K_UNLOCK: begin
              rhave_nxt = cur_v_r; rslot_nxt = cur_r;
              if (in_data.password != key_r) begin
                rst_code_nxt = mlfq_pkg::R_LOCKFAIL;
                if (cur_v_r) begin
                  addr_nxt = {1'b0, cur_r}; state_nxt = S_SINGLE;
                end
              end else begin
                lock_act_nxt = 1'b0;
              end
            end
            default: begin
              if (in_data.new_status == mlfq_pkg::ST_RUNNING ||
                  (cur_v_r && in_data.target_slot == cur_r)) begin
                rst_code_nxt = mlfq_pkg::R_IGNORED;
              end else begin
                rhave_nxt = 1'b1; rslot_nxt = in_data.target_slot;
                addr_nxt = {1'b0, in_data.target_slot}; state_nxt = S_SINGLE;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue next read while data of previous address arrives
        if (!addr_r[SB]) begin
          rv_nxt = 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
        last = !addr_r[SB] ? 1'b0 : !rv_r ? 1'b1 : 1'b0;
        if (rv_r) begin
          case (pass_r)
            P_ADMIT: begin
              if (e.status == mlfq_pkg::ST_FREE) begin
                we = 1'b1;
                wdata.status = mlfq_pkg::ST_RUNNABLE;
                wdata.pid = next_id_r;
                wdata.level = 2'd0;
                wdata.prio = 2'd3;
                wdata.birth = {2'b00, tick_r} + 10'd4;
                wdata.quantum = q0_r;
                wdata.locked = 1'b0;
                next_id_nxt = next_id_r + 1'b1;
                rhave_nxt = 1'b1; rslot_nxt = raddr_d_r;
                rv_nxt = 1'b0; state_nxt = S_EMIT;
              end
            end
            P_SETPR: begin
              if (e.status != mlfq_pkg::ST_FREE && e.pid == req_r.target_pid) begin
                we = 1'b1;
                wdata.prio = req_r.new_priority;
                rhave_nxt = 1'b1; rslot_nxt = raddr_d_r;
                rv_nxt = 1'b0; state_nxt = S_EMIT;
              end
            end
            P_BOOST: begin
              if (e.status == mlfq_pkg::ST_RUNNABLE &&
                  !(skip_v_r && raddr_d_r == skip_r)) begin
                we = 1'b1;
                if (e.level <= 2'd2) wdata.birth = 10'd1 + {8'd0, e.level};
                wdata.level = 2'd0;
                wdata.prio = 2'd3;
                wdata.quantum = q0_r;
              end
            end
            P_DSEL: begin
              if (e.status == mlfq_pkg::ST_RUNNABLE) begin
                if (e.locked) begin
                  we = 1'b1;
                  wdata.status = mlfq_pkg::ST_RUNNING;
                  cur_v_nxt = 1'b1; cur_nxt = raddr_d_r; by_lock_nxt = 1'b1;
                  rhave_nxt = 1'b1; rslot_nxt = raddr_d_r;
                  rv_nxt = 1'b0; state_nxt = S_EMIT;
                end else if (e.level <= 2'd2) begin
                  lvnz_nxt[e.level] = 1'b1;
                end
              end
            end
            P_DBEST: begin
              if (e.status == mlfq_pkg::ST_RUNNABLE && e.level == lvl_r &&
                  (!found_r || better(e, best_e_r, lvl_r))) begin
                found_nxt = 1'b1; best_nxt = raddr_d_r; best_e_nxt = e;
              end
            end
            default: begin
              if (e.status == mlfq_pkg::ST_RUNNABLE && e.level == lvl_r) begin
                we = 1'b1;
                wdata.birth = 10'd4;
              end
            end
          endcase
        end
        if (state_nxt == S_SCAN && addr_r[SB] && !rv_r) begin
          // pass finished
          addr_nxt = '0;
          case (pass_r)
            P_ADMIT: begin
              rst_code_nxt = mlfq_pkg::R_FULL; state_nxt = S_EMIT;
            end
            P_SETPR: begin
              rst_code_nxt = mlfq_pkg::R_IGNORED; state_nxt = S_EMIT;
            end
            P_BOOST: state_nxt = S_EMIT;
            P_DSEL: begin
              if (lvnz_r == 3'd0) begin
                rst_code_nxt = mlfq_pkg::R_NONE; state_nxt = S_EMIT;
              end else begin
                lw = lowest(lvnz_r);
                lvl_nxt = lw; found_nxt = 1'b0; pass_nxt = P_DBEST;
              end
            end
            P_DBEST: begin
              if (prev_lv_r != lvl_r) begin
                prev_lv_nxt = lvl_r; pass_nxt = P_LVRST;
              end else begin
                addr_nxt = {1'b0, best_r}; pass_nxt = P_LVRST; state_nxt = S_SINGLE;
              end
            end
            default: begin
              addr_nxt = {1'b0, best_r}; state_nxt = S_SINGLE;
            end
          endcase
        end
        if (last) rv_nxt = 1'b0;
      end

      S_SINGLE: begin
        // read issued while rv_r is low; data arrives once rv_r is high
        if (!rv_r) begin
          rv_nxt = 1'b1;
          raddr_d_nxt = addr_r[SB-1:0];
        end else begin
          state_nxt = S_EMIT;
          addr_nxt = '0;
          case (req_r.kind)
            mlfq_pkg::K_DISPATCH: begin
              we = 1'b1;
              wdata.status = mlfq_pkg::ST_RUNNING;
              cur_v_nxt = 1'b1; cur_nxt = raddr_d_r; by_lock_nxt = 1'b0;
              rhave_nxt = 1'b1; rslot_nxt = raddr_d_r;
            end
            mlfq_pkg::K_RETURN: begin
              we = 1'b1;
              wdata.status = req_r.still_runnable ? mlfq_pkg::ST_RUNNABLE :
                                                    mlfq_pkg::ST_BLOCKED;
              rhave_nxt = 1'b1; rslot_nxt = raddr_d_r;
              cur_v_nxt = 1'b0; by_lock_nxt = 1'b0;
              if (by_lock_r) begin
                if (tick_r == boost_r || !lock_act_r) begin
                  wdata.level = 2'd0; wdata.prio = 2'd3; wdata.birth = '0;
                  wdata.quantum = q0_r; wdata.locked = 1'b0;
                  prev_lv_nxt = 2'd0;
                end
                if (tick_r == boost_r) begin
                  tick_nxt = '0; lock_act_nxt = 1'b0;
                  pass_nxt = P_BOOST; skip_v_nxt = 1'b1; skip_nxt = raddr_d_r;
                  state_nxt = S_SCAN;
                end
              end else begin
                if (e.quantum != 8'd0) wdata.quantum = e.quantum - 8'd1;
                if (req_r.still_runnable) begin
                  if (wdata.quantum == 8'd0) begin
                    if (e.level == 2'd0) begin
                      wdata.level = 2'd1; wdata.quantum = q1_r;
                    end else begin
                      if (e.level >= 2'd2 && e.prio != 2'd0)
                        wdata.prio = e.prio - 2'd1;
                      wdata.level = 2'd2; wdata.quantum = q2_r;
                    end
                  end
                  wdata.birth = {2'b00, tick_r} + 10'd4;
                end
              end
            end
            mlfq_pkg::K_LOCK: begin
              we = 1'b1;
              wdata.locked = (rst_code_r == mlfq_pkg::R_OK);
            end
            mlfq_pkg::K_UNLOCK: begin
              we = 1'b1;
              wdata.locked = 1'b0;
            end
            default: begin
              we = 1'b1;
              wdata.status = req_r.new_status;
            end
          endcase
          rv_nxt = 1'b0;
        end
      end

      S_EMIT: begin
        // read reported slot (write of the prior cycle has landed)
        raddr = rslot_r;
        rv_nxt = 1'b0;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        raddr = rslot_r;
        if (out_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt.status = rst_code_r;
          odata_nxt.slot = rhave_r ? rslot_r : '0;
          odata_nxt.pid = rhave_r ? rdata.pid : '0;
          odata_nxt.level = rhave_r ? rdata.level : '0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r <= '0;
      rv_r <= 1'b0;
      tick_r <= '0;
      lock_act_r <= 1'b0;
      prev_lv_r <= '0;
      next_id_r <= mlfq_pkg::PID_BITS'(1);
      cur_v_r <= 1'b0;
      by_lock_r <= 1'b0;
      ovalid_r <= 1'b0;
      skip_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r <= addr_nxt;
      rv_r <= rv_nxt;
      tick_r <= tick_nxt;
      lock_act_r <= lock_act_nxt;
      prev_lv_r <= prev_lv_nxt;
      next_id_r <= next_id_nxt;
      cur_v_r <= cur_v_nxt;
      by_lock_r <= by_lock_nxt;
      ovalid_r <= ovalid_nxt;
      skip_v_r <= skip_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pass_r <= pass_nxt;
    req_r <= req_nxt;
    cur_r <= cur_nxt;
    raddr_d_r <= raddr_d_nxt;
    skip_r <= skip_nxt;
    found_r <= found_nxt;
    best_r <= best_nxt;
    best_e_r <= best_e_nxt;
    lvnz_r <= lvnz_nxt;
    lvl_r <= lvl_nxt;
    rst_code_r <= rst_code_nxt;
    rhave_r <= rhave_nxt;
    rslot_r <= rslot_nxt;
    odata_r <= odata_nxt;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");
  a_lock_cur: assert property (@(posedge clk) disable iff (!rst_n)
    by_lock_r |-> cur_v_r)
    else $error("lock dispatch flag without running slot");
endmodule

@@ sv/mlfq_ram.sv @@
// Single-port-write, single-read slot table with registered read data.
// Depends on mlfq_pkg for the entry type and depth.
module mlfq_ram (
  input  logic                           clk,
  input  logic                           we,
  input  logic [mlfq_pkg::SLOT_BITS-1:0] waddr,
  input  mlfq_pkg::slot_t                wdata,
  input  logic [mlfq_pkg::SLOT_BITS-1:0] raddr,
  output mlfq_pkg::slot_t                rdata
);
  mlfq_pkg::slot_t mem [mlfq_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
